FILE: rtl/dpd_pkg.sv
package dpd_pkg;

   // Packet geometry
   localparam int CHANNELS = 16;
   localparam int SAMPLES  = 64;
   localparam int TOTAL    = CHANNELS * SAMPLES;

   localparam int CHAN_W   = 4;
   localparam int COUNT_W  = 10;

   localparam logic [CHAN_W-1:0]  LAST_CHANNEL = CHAN_W'(CHANNELS - 1);
   localparam logic [COUNT_W-1:0] LAST_SAMPLE  = COUNT_W'(TOTAL - 1);

   // Stream markers
   localparam logic [15:0] START_MARK = 16'hA1FA;
   localparam logic [15:0] END_MARK   = 16'h0E6A;

   // Result kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      ST_HUNT     = 4'd0,
      ST_ADDR     = 4'd1,
      ST_TIME_HI  = 4'd2,
      ST_TIME_LO  = 4'd3,
      ST_TRIG     = 4'd4,
      ST_WINDOW   = 4'd5,
      ST_READ     = 4'd6,
      ST_STATUS   = 4'd7,
      ST_PAYLOAD  = 4'd8,
      ST_WAIT_END = 4'd9
   } parse_state_type;

   // One result beat, plus a flag that the word produced one
   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [7:0]        source_id;
      logic [7:0]        fine_stamp;
      logic [31:0]       coarse_stamp;
      logic [15:0]       trigger_id;
      logic [15:0]       window_settings;
      logic [15:0]       read_settings;
      logic [15:0]       trigger_status;
      logic [11:0]       sample_value;
      logic [CHAN_W-1:0] channel;
      logic              vector_last;
      logic              packet_last;
   } result_type;

endpackage

FILE: rtl/dpd_req_if.sv
interface dpd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/dpd_rsp_if.sv
interface dpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  source_id;
   logic [7:0]  fine_stamp;
   logic [31:0] coarse_stamp;
   logic [15:0] trigger_id;
   logic [15:0] window_settings;
   logic [15:0] read_settings;
   logic [15:0] trigger_status;
   logic [11:0] sample_value;
   logic [3:0]  channel;
   logic        vector_last;
   logic        packet_last;

   modport source (
      output valid, output kind, output source_id, output fine_stamp,
      output coarse_stamp, output trigger_id, output window_settings,
      output read_settings, output trigger_status, output sample_value,
      output channel, output vector_last, output packet_last,
      input ready
   );
   modport sink (
      input valid, input kind, input source_id, input fine_stamp,
      input coarse_stamp, input trigger_id, input window_settings,
      input read_settings, input trigger_status, input sample_value,
      input channel, input vector_last, input packet_last,
      output ready
   );
endinterface

FILE: rtl/dpd_parser.sv
module dpd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [15:0]          word,
   output dpd_pkg::result_type  result
);

   dpd_pkg::parse_state_type        state_ff, state_in;
   logic [dpd_pkg::CHAN_W-1:0]      channel_ff, channel_in;
   logic [dpd_pkg::COUNT_W-1:0]     sample_ff, sample_in;
   logic [15:0]                     address_ff, address_in;
   logic [31:0]                     coarse_ff, coarse_in;
   logic [15:0]                     trigger_ff, trigger_in;
   logic [15:0]                     window_ff, window_in;
   logic [15:0]                     read_ff, read_in;

   // State and header holds advance only when the word is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dpd_pkg::ST_HUNT;
         channel_ff <= '0;
         sample_ff  <= '0;
         address_ff <= '0;
         coarse_ff  <= '0;
         trigger_ff <= '0;
         window_ff  <= '0;
         read_ff    <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         channel_ff <= channel_in;
         sample_ff  <= sample_in;
         address_ff <= address_in;
         coarse_ff  <= coarse_in;
         trigger_ff <= trigger_in;
         window_ff  <= window_in;
         read_ff    <= read_in;
      end
   end

   // Next state and result for the current word
   always_comb begin
      state_in   = state_ff;
      channel_in = channel_ff;
      sample_in  = sample_ff;
      address_in = address_ff;
      coarse_in  = coarse_ff;
      trigger_in = trigger_ff;
      window_in  = window_ff;
      read_in    = read_ff;
      result     = '0;

      unique case (state_ff)
         dpd_pkg::ST_ADDR: begin
            address_in = word;
            state_in   = dpd_pkg::ST_TIME_HI;
         end
         dpd_pkg::ST_TIME_HI: begin
            coarse_in = {word, 16'h0000};
            state_in  = dpd_pkg::ST_TIME_LO;
         end
         dpd_pkg::ST_TIME_LO: begin
            coarse_in = {coarse_ff[31:16], word};
            state_in  = dpd_pkg::ST_TRIG;
         end
         dpd_pkg::ST_TRIG: begin
            trigger_in = word;
            state_in   = dpd_pkg::ST_WINDOW;
         end
         dpd_pkg::ST_WINDOW: begin
            window_in = word;
            state_in  = dpd_pkg::ST_READ;
         end
         dpd_pkg::ST_READ: begin
            read_in  = word;
            state_in = dpd_pkg::ST_STATUS;
         end
         dpd_pkg::ST_STATUS: begin
            // last header word: emit the header beat
            result.valid           = 1'b1;
            result.kind            = dpd_pkg::KIND_HEADER;
            result.source_id       = address_ff[15:8];
            result.fine_stamp      = address_ff[7:0];
            result.coarse_stamp    = coarse_ff;
            result.trigger_id      = trigger_ff;
            result.window_settings = window_ff;
            result.read_settings   = read_ff;
            result.trigger_status  = word;
            state_in               = dpd_pkg::ST_PAYLOAD;
         end
         dpd_pkg::ST_PAYLOAD: begin
            result.valid        = 1'b1;
            result.kind         = dpd_pkg::KIND_SAMPLE;
            result.sample_value = word[11:0];
            result.channel      = channel_ff;
            result.vector_last  = (channel_ff == dpd_pkg::LAST_CHANNEL);
            result.packet_last  = (sample_ff == dpd_pkg::LAST_SAMPLE);
            channel_in = (channel_ff == dpd_pkg::LAST_CHANNEL) ? '0 : channel_ff + 1'b1;
            if (sample_ff == dpd_pkg::LAST_SAMPLE) begin
               sample_in  = '0;
               channel_in = '0;
               state_in   = dpd_pkg::ST_WAIT_END;
            end else begin
               sample_in = sample_ff + 1'b1;
            end
         end
         dpd_pkg::ST_WAIT_END: begin
            if (word == dpd_pkg::END_MARK) state_in = dpd_pkg::ST_HUNT;
         end
         default: begin
            // hunting, and any stray code
            channel_in = '0;
            sample_in  = '0;
            state_in   = (word == dpd_pkg::START_MARK) ? dpd_pkg::ST_ADDR
                                                       : dpd_pkg::ST_HUNT;
         end
      endcase
   end

endmodule

FILE: rtl/detector_packet_deframer.sv
// Deframes a detector readout stream of 16-bit words. After the start marker
// 0xA1FA and seven header words it delivers one header beat, then one sample
// beat per payload word (16 channels x 64 samples, channel index and
// vector/packet last flags attached), then ignores words until the end
// marker 0x0E6A and hunts again. One word is accepted every cycle while ready
// is high; a word passes through an input register into the result register,
// where its result beat is held until the result side takes it. Ready on the
// input is low during reset; otherwise it drops only while both registers
// hold beats and the result side stalls.
module detector_packet_deframer (
   input  logic       clock,
   input  logic       reset,
   dpd_req_if.sink    req,
   dpd_rsp_if.source  rsp
);

   logic                s1_valid_ff, s1_valid_in;
   logic [15:0]         s1_word_ff;
   logic                out_valid_ff, out_valid_in;
   dpd_pkg::result_type out_ff;
   dpd_pkg::result_type parse_result;
   logic                out_free;
   logic                advance;

   // Handshake: input stage drains whenever the result register can load
   assign out_free    = !out_valid_ff || rsp.ready;
   assign advance     = s1_valid_ff && out_free;
   assign req.ready   = !reset && (!s1_valid_ff || advance);
   assign s1_valid_in = req.ready ? req.valid : s1_valid_ff;
   assign out_valid_in = out_free ? (advance && parse_result.valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) s1_word_ff <= req.word;
      if (advance && parse_result.valid) out_ff <= parse_result;
   end

   dpd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (s1_word_ff),
      .result (parse_result)
   );

   // Result beat
   assign rsp.valid           = out_valid_ff;
   assign rsp.kind            = out_ff.kind;
   assign rsp.source_id       = out_ff.source_id;
   assign rsp.fine_stamp      = out_ff.fine_stamp;
   assign rsp.coarse_stamp    = out_ff.coarse_stamp;
   assign rsp.trigger_id      = out_ff.trigger_id;
   assign rsp.window_settings = out_ff.window_settings;
   assign rsp.read_settings   = out_ff.read_settings;
   assign rsp.trigger_status  = out_ff.trigger_status;
   assign rsp.sample_value    = out_ff.sample_value;
   assign rsp.channel         = out_ff.channel;
   assign rsp.vector_last     = out_ff.vector_last;
   assign rsp.packet_last     = out_ff.packet_last;

   // Checks
   a_packet_ends_vector: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.kind == dpd_pkg::KIND_SAMPLE && rsp.packet_last |-> rsp.vector_last)
      else $error("packet ended mid vector");

   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.kind == dpd_pkg::KIND_HEADER |->
         rsp.sample_value == '0 && rsp.channel == '0 && !rsp.vector_last && !rsp.packet_last)
      else $error("header beat carries sample fields");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> s1_valid_ff && rsp.valid && !rsp.ready)
      else $error("input stalled without output backpressure");

endmodule
